FILE: rtl/core/imm_pkg.sv
// Shared types, codes and helper functions for the integer matrix multiply core.
// Used by integer_matrix_multiply_core and imm_ram; depends on nothing else.
package imm_pkg;

    localparam int MAX_DIM_DEF = 16;
    localparam int DIM_W       = 5;
    localparam int IDX_W       = 4;
    localparam int DATA_W      = 32;
    localparam int KIND_W      = 2;
    localparam int CMD_W       = 2;
    localparam int CFG_IDX_W   = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_A  = 2'd0,
        CMD_LOAD_B  = 2'd1,
        CMD_COMPUTE = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_A_ROWS    = 2'd0,
        CFG_INNER_LEN = 2'd1,
        CFG_B_COLS    = 2'd2,
        CFG_ELEM_KIND = 2'd3
    } cfg_idx_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_INT32 = 2'd0,
        KIND_INT8  = 2'd1,
        KIND_UINT8 = 2'd2,
        KIND_RSVD  = 2'd3
    } kind_t;

    typedef enum logic {
        ST_IDLE,
        ST_MAC
    } state_t;

    // A dimension above the storage size behaves as the storage size.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] dim,
                                                   input int maxd);
        logic [DIM_W-1:0] res;
        res = dim;
        if (int'(dim) > maxd)
        begin
            res = DIM_W'(maxd);
        end
        return res;
    endfunction

    // Wrap a 32-bit sum to the element type and extend it back to 32 bits.
    function automatic logic [DATA_W-1:0] wrap_kind(input logic [DATA_W-1:0] sum,
                                                    input logic [KIND_W-1:0] kind);
        logic [DATA_W-1:0] res;
        res = sum;
        case (kind)
            KIND_INT8:  res = {{(DATA_W-8){sum[7]}}, sum[7:0]};
            KIND_UINT8: res = {{(DATA_W-8){1'b0}}, sum[7:0]};
            default:    res = sum;
        endcase
        return res;
    endfunction

endpackage

FILE: rtl/core/integer_matrix_multiply_core.sv
// Integer matrix multiply core: two element stores and a multiply-accumulate sequencer.
// Depends on imm_pkg and instantiates imm_ram twice.
//
// The core holds matrix A (a_rows by inner_len) and matrix B (inner_len by b_cols)
// in two RAMs of MAX_DIM*MAX_DIM words, one element loaded per input beat. A load
// makes no output beat; a load outside the configured dimensions is dropped. A
// compute beat names an output row and column and returns one output beat with
// the dot product of that A row and B column, wrapped to the element type
// chosen by elem_kind (int32, int8 or uint8, the 8-bit results sign or zero
// extended). A compute outside the dimensions returns a zero value with
// err_status set in the cycle after acceptance. An in-range compute streams the
// operand pairs out of both RAMs one per cycle through a read stage, a
// registered 32x32 multiplier and an accumulator; the single read port of each
// RAM sets that pace. While a compute is in progress the input is stalled.
// A finished result waits in the output register while loads continue to be
// accepted; a further compute beat waits until that result has been taken.
// Reading an element that was never loaded gives an undefined value. The
// dimension and element-type registers are written through the cfg port and
// should be changed only while the core is idle.
module integer_matrix_multiply_core #(
    parameter int MAX_DIM = imm_pkg::MAX_DIM_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write port
    input  logic                          cfg_we,
    input  logic [imm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [imm_pkg::DIM_W-1:0]     cfg_data,
    // input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [imm_pkg::CMD_W-1:0]     cmd,
    input  logic [imm_pkg::IDX_W-1:0]     row_sel,
    input  logic [imm_pkg::IDX_W-1:0]     col_sel,
    input  logic signed [imm_pkg::DATA_W-1:0] elem_value,
    // output channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [imm_pkg::DATA_W-1:0] product_value,
    output logic                          err_status
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int DIM_W  = imm_pkg::DIM_W;
    localparam int IDX_W  = imm_pkg::IDX_W;
    localparam int DATA_W = imm_pkg::DATA_W;

    // Configuration registers.
    logic [DIM_W-1:0]          a_rows_reg;
    logic [DIM_W-1:0]          inner_len_reg;
    logic [DIM_W-1:0]          b_cols_reg;
    logic [imm_pkg::KIND_W-1:0] elem_kind_reg;

    // Sequencer state.
    imm_pkg::state_t   state_reg, state_next;
    logic [IDX_W-1:0]  row_reg;
    logic [IDX_W-1:0]  col_reg;
    logic [DIM_W-1:0]  n_reg;
    logic [DIM_W-1:0]  k_reg;
    logic              rd_v_reg;
    logic              mul_v_reg;
    logic [DATA_W-1:0] prod_reg;
    logic [DATA_W-1:0] acc_reg;

    // Output register.
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_value_reg;
    logic              out_err_reg;

    // Effective dimensions after clamping to the store size.
    logic [DIM_W-1:0] dim_m;
    logic [DIM_W-1:0] dim_n;
    logic [DIM_W-1:0] dim_p;

    logic             in_acc;
    logic             out_take;
    logic             is_load_a;
    logic             is_load_b;
    logic             is_compute;
    logic             row_lt_m;
    logic             row_lt_n;
    logic             col_lt_n;
    logic             col_lt_p;
    logic             cmp_ok;
    logic             issue;
    logic             done;

    logic              a_we;
    logic              b_we;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] a_raddr;
    logic [ADDR_W-1:0] b_raddr;
    logic [DATA_W-1:0] a_q;
    logic [DATA_W-1:0] b_q;

    assign dim_m = imm_pkg::clamp_dim(a_rows_reg, MAX_DIM);
    assign dim_n = imm_pkg::clamp_dim(inner_len_reg, MAX_DIM);
    assign dim_p = imm_pkg::clamp_dim(b_cols_reg, MAX_DIM);

    assign is_load_a  = (cmd == imm_pkg::CMD_LOAD_A);
    assign is_load_b  = (cmd == imm_pkg::CMD_LOAD_B);
    assign is_compute = (cmd == imm_pkg::CMD_COMPUTE);

    assign row_lt_m = ({1'b0, row_sel} < dim_m);
    assign row_lt_n = ({1'b0, row_sel} < dim_n);
    assign col_lt_n = ({1'b0, col_sel} < dim_n);
    assign col_lt_p = ({1'b0, col_sel} < dim_p);
    assign cmp_ok   = row_lt_m && col_lt_p;

    assign in_acc   = in_valid && !in_stall;
    assign out_take = out_valid_reg && !out_stall;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_rows_reg    <= DIM_W'(16);
            inner_len_reg <= DIM_W'(16);
            b_cols_reg    <= DIM_W'(16);
            elem_kind_reg <= imm_pkg::KIND_INT32;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                imm_pkg::CFG_A_ROWS:    a_rows_reg    <= cfg_data;
                imm_pkg::CFG_INNER_LEN: inner_len_reg <= cfg_data;
                imm_pkg::CFG_B_COLS:    b_cols_reg    <= cfg_data;
                imm_pkg::CFG_ELEM_KIND: elem_kind_reg <= cfg_data[imm_pkg::KIND_W-1:0];
                default:                ;
            endcase
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            imm_pkg::ST_IDLE:
            begin
                if (in_acc && is_compute && cmp_ok)
                begin
                    state_next = imm_pkg::ST_MAC;
                end
            end
            imm_pkg::ST_MAC:
            begin
                if (done)
                begin
                    state_next = imm_pkg::ST_IDLE;
                end
            end
            default: state_next = imm_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs. A compute beat is held off while a result still waits.
    always_comb
    begin
        in_stall = 1'b1;
        issue    = 1'b0;
        done     = 1'b0;
        unique case (state_reg)
            imm_pkg::ST_IDLE:
            begin
                in_stall = out_valid_reg && is_compute;
            end
            imm_pkg::ST_MAC:
            begin
                issue = (k_reg < n_reg);
                done  = (k_reg >= n_reg) && !rd_v_reg && !mul_v_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= imm_pkg::ST_IDLE;
            rd_v_reg  <= 1'b0;
            mul_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rd_v_reg  <= issue;
            mul_v_reg <= rd_v_reg;
        end
    end

    // Operand walk and multiply-accumulate datapath.
    always_ff @(posedge clk)
    begin
        if (in_acc && is_compute)
        begin
            row_reg <= row_sel;
            col_reg <= col_sel;
            n_reg   <= dim_n;
            k_reg   <= '0;
            acc_reg <= '0;
        end
        else
        begin
            if (issue)
            begin
                k_reg <= k_reg + DIM_W'(1);
            end
            if (mul_v_reg)
            begin
                acc_reg <= acc_reg + prod_reg;
            end
        end
        if (rd_v_reg)
        begin
            prod_reg <= DATA_W'(a_q * b_q);
        end
    end

    // Output register: filled by an out-of-range compute or a finished sum.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done || (in_acc && is_compute && !cmp_ok))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            out_value_reg <= imm_pkg::wrap_kind(acc_reg, elem_kind_reg);
            out_err_reg   <= 1'b0;
        end
        else if (in_acc && is_compute && !cmp_ok)
        begin
            out_value_reg <= '0;
            out_err_reg   <= 1'b1;
        end
    end

    assign out_valid     = out_valid_reg;
    assign product_value = out_value_reg;
    assign err_status    = out_err_reg;

    // Store addressing: entry index is row * MAX_DIM + column.
    assign a_we    = in_acc && is_load_a && row_lt_m && col_lt_n;
    assign b_we    = in_acc && is_load_b && row_lt_n && col_lt_p;
    assign wr_addr = ADDR_W'(int'(row_sel) * MAX_DIM + int'(col_sel));
    assign a_raddr = ADDR_W'(int'(row_reg) * MAX_DIM + int'(k_reg));
    assign b_raddr = ADDR_W'(int'(k_reg) * MAX_DIM + int'(col_reg));

    imm_ram #(
        .WIDTH  (DATA_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_a_store (
        .clk   (clk),
        .we    (a_we),
        .waddr (wr_addr),
        .wdata (elem_value),
        .re    (issue),
        .raddr (a_raddr),
        .rdata (a_q)
    );

    imm_ram #(
        .WIDTH  (DATA_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_b_store (
        .clk   (clk),
        .we    (b_we),
        .waddr (wr_addr),
        .wdata (elem_value),
        .re    (issue),
        .raddr (b_raddr),
        .rdata (b_q)
    );

endmodule

FILE: rtl/core/imm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on imm_pkg for its parameter defaults; used for both matrix stores of the core.
module imm_ram #(
    parameter int WIDTH  = imm_pkg::DATA_W,
    parameter int DEPTH  = imm_pkg::MAX_DIM_DEF * imm_pkg::MAX_DIM_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: test/integer_matrix_multiply_core_tb.sv
// Self-checking testbench for integer_matrix_multiply_core: directed and random
// load/compute beats under several dimension and element-type settings.
// Depends on imm_pkg and the core RTL only.
module integer_matrix_multiply_core_tb;

    // Cycles to let pass before a register write, so that a load still
    // in flight has settled.
    localparam int SETTLE_CYCLES = imm_pkg::MAX_DIM_DEF + 8;
    // Long receiver hold-off used to back the core up into its input.
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int STORE_DEPTH = imm_pkg::MAX_DIM_DEF * imm_pkg::MAX_DIM_DEF;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        logic [imm_pkg::DATA_W-1:0] value;
        logic                       err;
    } product_beat_t;

    // Scoreboard: keeps its own copy of both element stores and of the
    // configuration, predicts the product for every accepted compute beat and
    // compares each output beat against the oldest prediction.
    class matmul_scoreboard;
        logic [imm_pkg::DATA_W-1:0] a_words [STORE_DEPTH];
        logic [imm_pkg::DATA_W-1:0] b_words [STORE_DEPTH];
        logic [imm_pkg::DIM_W-1:0]  rows_reg;
        logic [imm_pkg::DIM_W-1:0]  inner_reg;
        logic [imm_pkg::DIM_W-1:0]  cols_reg;
        imm_pkg::kind_t             kind_reg;
        product_beat_t              pending_products[$];
        int                         mismatches;

        function new();
            rows_reg   = imm_pkg::DIM_W'(16);
            inner_reg  = imm_pkg::DIM_W'(16);
            cols_reg   = imm_pkg::DIM_W'(16);
            kind_reg   = imm_pkg::KIND_INT32;
            mismatches = 0;
        endfunction

        function int effective_dim(logic [imm_pkg::DIM_W-1:0] d);
            return (int'(d) > imm_pkg::MAX_DIM_DEF) ? imm_pkg::MAX_DIM_DEF : int'(d);
        endfunction

        function void write_reg(imm_pkg::cfg_idx_t idx, logic [imm_pkg::DIM_W-1:0] data);
            case (idx)
                imm_pkg::CFG_A_ROWS:    rows_reg  = data;
                imm_pkg::CFG_INNER_LEN: inner_reg = data;
                imm_pkg::CFG_B_COLS:    cols_reg  = data;
                default:                kind_reg  = imm_pkg::kind_t'(data[imm_pkg::KIND_W-1:0]);
            endcase
        endfunction

        function int pending();
            return pending_products.size();
        endfunction

        function void note_beat(imm_pkg::cmd_t op, logic [imm_pkg::IDX_W-1:0] r,
                                logic [imm_pkg::IDX_W-1:0] c,
                                logic [imm_pkg::DATA_W-1:0] v);
            int                         m;
            int                         n;
            int                         p;
            int                         k;
            logic [imm_pkg::DATA_W-1:0] acc;
            product_beat_t              e;
            m = effective_dim(rows_reg);
            n = effective_dim(inner_reg);
            p = effective_dim(cols_reg);
            case (op)
                imm_pkg::CMD_LOAD_A:
                begin
                    if (r < m && c < n)
                    begin
                        a_words[r*imm_pkg::MAX_DIM_DEF + c] = v;
                    end
                end
                imm_pkg::CMD_LOAD_B:
                begin
                    if (r < n && c < p)
                    begin
                        b_words[r*imm_pkg::MAX_DIM_DEF + c] = v;
                    end
                end
                imm_pkg::CMD_COMPUTE:
                begin
                    if (r >= m || c >= p)
                    begin
                        e.value = '0;
                        e.err   = 1'b1;
                    end
                    else
                    begin
                        acc = '0;
                        for (k = 0; k < n; k++)
                        begin
                            acc = acc + a_words[r*imm_pkg::MAX_DIM_DEF + k]
                                      * b_words[k*imm_pkg::MAX_DIM_DEF + c];
                        end
                        case (kind_reg)
                            imm_pkg::KIND_INT8:
                                e.value = {{(imm_pkg::DATA_W-8){acc[7]}}, acc[7:0]};
                            imm_pkg::KIND_UINT8:
                                e.value = {{(imm_pkg::DATA_W-8){1'b0}}, acc[7:0]};
                            default:
                                e.value = acc;
                        endcase
                        e.err = 1'b0;
                    end
                    pending_products = {pending_products, e};
                end
                default:
                begin
                end
            endcase
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_product(logic [imm_pkg::DATA_W-1:0] got_value, logic got_err);
            product_beat_t e;
            if (pending_products.size() == 0)
            begin
                report($sformatf("output beat value=%h err=%b with nothing expected",
                                 got_value, got_err));
                return;
            end
            e = pending_products.pop_front();
            if (got_value !== e.value)
            begin
                report($sformatf("product_value %h, expected %h", got_value, e.value));
            end
            if (got_err !== e.err)
            begin
                report($sformatf("err_status %b, expected %b", got_err, e.err));
            end
        endtask
    endclass

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              cfg_we = 1'b0;
    logic [imm_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [imm_pkg::DIM_W-1:0]         cfg_data = '0;
    logic                              in_valid = 1'b0;
    logic                              in_stall;
    logic [imm_pkg::CMD_W-1:0]         cmd = '0;
    logic [imm_pkg::IDX_W-1:0]         row_sel = '0;
    logic [imm_pkg::IDX_W-1:0]         col_sel = '0;
    logic signed [imm_pkg::DATA_W-1:0] elem_value = '0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic signed [imm_pkg::DATA_W-1:0] product_value;
    logic                              err_status;

    matmul_scoreboard sb = new();

    // Stimulus-side view of the configuration and of which store entries hold
    // data. A compute is only issued once every operand it reads was loaded.
    int cur_m = 16;
    int cur_n = 16;
    int cur_p = 16;
    bit a_loaded [STORE_DEPTH];
    bit b_loaded [STORE_DEPTH];
    int beats_sent;
    int sender_idle_pct = 0;
    int recv_stall_pct = 0;
    // Hold-offs asked for by the stimulus and hold-offs started by the receiver.
    int hold_count = 0;
    int hold_seen;
    int hold_left;

    integer_matrix_multiply_core #(
        .MAX_DIM (imm_pkg::MAX_DIM_DEF)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .row_sel       (row_sel),
        .col_sel       (col_sel),
        .elem_value    (elem_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .product_value (product_value),
        .err_status    (err_status)
    );

    always #5 clk = ~clk;

    // Receiver. A new hold-off request from the stimulus is picked up here and
    // counted down one cycle at a time; otherwise the stall is random at the
    // rate of the current phase.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
            hold_seen <= 0;
        end
        else if (hold_seen != hold_count)
        begin
            out_stall <= 1'b1;
            hold_left <= HOLD_OFF_CYCLES - 1;
            hold_seen <= hold_count;
        end
        else if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Monitor. Both channels are sampled at the clock edge with the values that
    // were stable before it, so the order of processes in a time step does not
    // matter. Every accepted input beat goes to the predictor, every accepted
    // output beat to the checker.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                sb.note_beat(imm_pkg::cmd_t'(cmd), row_sel, col_sel, elem_value);
            end
            if (out_valid && !out_stall)
            begin
                sb.check_product(product_value, err_status);
            end
        end
    end

    // Value mix for loads: the signed and unsigned extremes show up often so that
    // products and sums wrap, small values keep the 8-bit modes interesting.
    function automatic logic [imm_pkg::DATA_W-1:0] rand_elem();
        logic [imm_pkg::DATA_W-1:0] v;
        case ($urandom_range(7))
            0:       v = 32'h0000_0000;
            1:       v = 32'hFFFF_FFFF;
            2:       v = 32'h7FFF_FFFF;
            3:       v = 32'h8000_0000;
            4:       v = imm_pkg::DATA_W'(int'($urandom_range(255)) - 128);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Offer one input beat and hold it until the core takes it. Random idle
    // cycles go in front of the beat; valid never looks at the stall.
    task automatic send_beat(imm_pkg::cmd_t op, int r, int c,
                             logic [imm_pkg::DATA_W-1:0] v);
        while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= op;
        row_sel    <= imm_pkg::IDX_W'(r);
        col_sel    <= imm_pkg::IDX_W'(c);
        elem_value <= v;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        // Track what the core should now hold; ignored beats do not count.
        case (op)
            imm_pkg::CMD_LOAD_A:
            begin
                if (r < cur_m && c < cur_n)
                begin
                    a_loaded[r*imm_pkg::MAX_DIM_DEF + c] = 1'b1;
                    beats_sent++;
                end
            end
            imm_pkg::CMD_LOAD_B:
            begin
                if (r < cur_n && c < cur_p)
                begin
                    b_loaded[r*imm_pkg::MAX_DIM_DEF + c] = 1'b1;
                    beats_sent++;
                end
            end
            imm_pkg::CMD_COMPUTE: beats_sent++;
            default:
            begin
            end
        endcase
    endtask

    // A well-formed dot product: load whatever part of the A row and B column
    // is still empty (and, with refresh set, overwrite some of the rest with
    // fresh values), then ask for the element. Out of range goes straight to
    // the compute, which must come back as an error.
    task automatic dot_sequence(int r, int c, bit refresh);
        int k;
        if (r < cur_m && c < cur_p)
        begin
            for (k = 0; k < cur_n; k++)
            begin
                if (!a_loaded[r*imm_pkg::MAX_DIM_DEF + k] ||
                    (refresh && $urandom_range(3) == 0))
                begin
                    send_beat(imm_pkg::CMD_LOAD_A, r, k, rand_elem());
                end
                if (!b_loaded[k*imm_pkg::MAX_DIM_DEF + c] ||
                    (refresh && $urandom_range(3) == 0))
                begin
                    send_beat(imm_pkg::CMD_LOAD_B, k, c, rand_elem());
                end
            end
        end
        send_beat(imm_pkg::CMD_COMPUTE, r, c, rand_elem());
    endtask

    // Stop offering beats and wait until every predicted product has come
    // back, then let any load still in flight settle.
    task automatic drain();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all four registers, one per cycle, only while the core is idle.
    task automatic write_config(logic [imm_pkg::DIM_W-1:0] m, logic [imm_pkg::DIM_W-1:0] n,
                                logic [imm_pkg::DIM_W-1:0] p,
                                logic [imm_pkg::DIM_W-1:0] kind_raw);
        imm_pkg::cfg_idx_t         idx [4];
        logic [imm_pkg::DIM_W-1:0] val [4];
        int                        i;
        idx = '{imm_pkg::CFG_A_ROWS, imm_pkg::CFG_INNER_LEN, imm_pkg::CFG_B_COLS,
                imm_pkg::CFG_ELEM_KIND};
        val = '{m, n, p, kind_raw};
        for (i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            sb.write_reg(idx[i], val[i]);
        end
        cfg_we <= 1'b0;
        cur_m = sb.effective_dim(m);
        cur_n = sb.effective_dim(n);
        cur_p = sb.effective_dim(p);
    endtask

    task automatic set_idle(idle_mode_t mode);
        case (mode)
            IDLE_SENDER:
            begin
                sender_idle_pct = 48;
                recv_stall_pct  = 0;
            end
            IDLE_RECEIVER:
            begin
                sender_idle_pct = 0;
                recv_stall_pct  = 48;
            end
            IDLE_BOTH:
            begin
                sender_idle_pct = 36;
                recv_stall_pct  = 36;
            end
            default:
            begin
                sender_idle_pct = 0;
                recv_stall_pct  = 0;
            end
        endcase
    endtask

    // One random phase. Most of the traffic is complete dot-product sequences
    // inside the configured matrices; the rest are computes anywhere, loads
    // anywhere (many of them ignored) and the unused command. With a hold-off
    // the receiver stops for a long stretch a quarter of the way in while the
    // beats keep coming, so the core backs up and stalls its input.
    task automatic random_phase(logic [imm_pkg::DIM_W-1:0] m, logic [imm_pkg::DIM_W-1:0] n,
                                logic [imm_pkg::DIM_W-1:0] p,
                                logic [imm_pkg::DIM_W-1:0] kind_raw,
                                idle_mode_t mode, int target, bit with_hold);
        int pick;
        bit held;
        drain();
        write_config(m, n, p, kind_raw);
        set_idle(mode);
        beats_sent = 0;
        held = 1'b0;
        while (beats_sent < target)
        begin
            if (with_hold && !held && beats_sent >= target / 4)
            begin
                hold_count++;
                held = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 55 && cur_m > 0 && cur_p > 0)
            begin
                dot_sequence($urandom_range(cur_m - 1), $urandom_range(cur_p - 1), 1'b1);
            end
            else if (pick < 70)
            begin
                dot_sequence($urandom_range(15), $urandom_range(15), 1'b0);
            end
            else if (pick < 95)
            begin
                send_beat(($urandom_range(1) != 0) ? imm_pkg::CMD_LOAD_B : imm_pkg::CMD_LOAD_A,
                          $urandom_range(15), $urandom_range(15), rand_elem());
            end
            else
            begin
                send_beat(imm_pkg::CMD_NONE, $urandom_range(15), $urandom_range(15),
                          rand_elem());
            end
        end
    endtask

    initial
    begin
        int i;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats with a one-long dot product: the most negative value
        // times minus one, the largest positive value squared and times minus
        // one, a zero operand, loads outside the matrices and the unused command.
        write_config(5'd16, 5'd1, 5'd16, 5'(imm_pkg::KIND_INT32));
        send_beat(imm_pkg::CMD_LOAD_A, 15, 0, 32'h8000_0000);
        send_beat(imm_pkg::CMD_LOAD_B, 0, 15, 32'hFFFF_FFFF);
        send_beat(imm_pkg::CMD_COMPUTE, 15, 15, 32'h0000_0000);
        send_beat(imm_pkg::CMD_LOAD_A, 0, 0, 32'h7FFF_FFFF);
        send_beat(imm_pkg::CMD_LOAD_B, 0, 0, 32'h7FFF_FFFF);
        send_beat(imm_pkg::CMD_COMPUTE, 0, 0, 32'hFFFF_FFFF);
        send_beat(imm_pkg::CMD_LOAD_A, 0, 5, 32'h5555_5555);
        send_beat(imm_pkg::CMD_LOAD_B, 3, 0, 32'hAAAA_AAAA);
        send_beat(imm_pkg::CMD_NONE, 15, 15, 32'hFFFF_FFFF);
        send_beat(imm_pkg::CMD_COMPUTE, 0, 15, 32'h1234_5678);
        send_beat(imm_pkg::CMD_LOAD_A, 7, 0, 32'h0000_0000);
        send_beat(imm_pkg::CMD_LOAD_B, 0, 7, 32'h1234_5678);
        send_beat(imm_pkg::CMD_COMPUTE, 7, 7, 32'h0000_0000);

        // Small matrices in int8: computes past the last row and the last
        // column come back as errors, and an in-range sum wraps to 8 bits.
        drain();
        write_config(5'd3, 5'd2, 5'd3, 5'(imm_pkg::KIND_INT8));
        send_beat(imm_pkg::CMD_COMPUTE, 3, 0, 32'h0000_0000);
        send_beat(imm_pkg::CMD_COMPUTE, 0, 3, 32'h0000_0000);
        send_beat(imm_pkg::CMD_COMPUTE, 15, 15, 32'hFFFF_FFFF);
        send_beat(imm_pkg::CMD_LOAD_A, 0, 1, 32'h0000_0181);
        send_beat(imm_pkg::CMD_LOAD_B, 1, 0, 32'hFFFF_FF01);
        send_beat(imm_pkg::CMD_COMPUTE, 0, 0, 32'h0000_0000);

        // Random phases. Besides the normal range they cover registers above
        // the storage size with the reserved element kind, a zero row or
        // column count (every compute an error) and a zero inner length
        // (every load ignored, every in-range compute zero).
        random_phase(5'd16, 5'd16, 5'd16, 5'(imm_pkg::KIND_INT32), IDLE_NONE, 300, 1'b1);
        random_phase(5'd4, 5'd3, 5'd5, 5'(imm_pkg::KIND_INT8), IDLE_SENDER, 250, 1'b0);
        random_phase(5'd1, 5'd1, 5'd1, 5'(imm_pkg::KIND_UINT8), IDLE_RECEIVER, 150, 1'b0);
        random_phase(5'd31, 5'd17, 5'd20, 5'b11111, IDLE_BOTH, 250, 1'b0);
        random_phase(5'd0, 5'd5, 5'd7, 5'b10101, IDLE_NONE, 60, 1'b0);
        random_phase(5'd9, 5'd12, 5'd0, 5'b01010, IDLE_SENDER, 60, 1'b0);
        random_phase(5'd6, 5'd0, 5'd11, 5'(imm_pkg::KIND_INT32), IDLE_RECEIVER, 60, 1'b0);
        random_phase(5'd16, 5'd8, 5'd16, 5'(imm_pkg::KIND_UINT8), IDLE_BOTH, 300, 1'b0);
        for (i = 0; i < 4; i++)
        begin
            random_phase(5'($urandom_range(1, 16)), 5'($urandom_range(1, 16)),
                         5'($urandom_range(1, 16)), 5'($urandom_range(0, 2)),
                         idle_mode_t'(i), 150, i == 2);
        end

        // Quiet the sender, wait for the last products and watch for strays.
        drain();
        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run, hold-offs included.
    initial
    begin
        #20000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
